// ===== design/dmrq_pkg.sv =====
// Shared types and constants of the delimited message ring queue.
`timescale 1ns / 1ps

package dmrq_pkg;

   // Most payload bytes a single pop may return.
   localparam int RESULT_CAP = 32;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);
   localparam int IDX_W      = $clog2(RESULT_CAP);

   localparam logic [7:0] SEPARATOR_RESET = 8'd10;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd2;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd3;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic [5:0] message_length;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       byte_valid;
      logic       last_out;
      logic [1:0] status;
      logic       is_empty;
      logic [8:0] free_count;
   } rsp_type;

   // Decoded command handed from the front to the back.
   typedef struct packed {
      logic       is_pop;
      logic [7:0] data;
      logic [5:0] len;
      logic       last;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEP,
      ST_RESULT,
      ST_WALK_WAIT,
      ST_WALK_CHECK,
      ST_EMIT
   } back_state_type;

endpackage

// ===== design/dmrq_front.sv =====
// Front end: accepts request items, decodes them and queues the commands.
`timescale 1ns / 1ps

module dmrq_front
   import dmrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_item,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_en, rd_en;
   cmd_type    decoded;

   always_comb begin
      decoded.is_pop = (req_item.mode == MODE_POP);
      decoded.data   = req_item.data_byte;
      decoded.len    = req_item.message_length;
      decoded.last   = req_item.last_byte;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign wr_en     = req_push && !req_full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== design/dmrq_back.sv =====
// Back end: byte ring, push bookkeeping and the pop walk.
`timescale 1ns / 1ps

module dmrq_back
   import dmrq_pkg::*;
#(
   parameter int RING_DEPTH  = 256,
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_take,
   input  logic [7:0] separator,
   output logic       rsp_push,
   output rsp_type    rsp_item,
   input  logic       rsp_full
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FREE_W = $clog2(RING_DEPTH + 1);

   back_state_type state_ff, state_in;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic              inside_ff, inside_in;
   logic              acc_ff, acc_in;
   logic              rej_ff, rej_in;
   logic [5:0]        bw_ff, bw_in;
   logic [5:0]        decl_ff, decl_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [7:0]        ring_mem [RING_DEPTH];
   logic [7:0]        ring_rd_ff;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [7:0]        mem_wdata;

   logic [7:0]        buf_ff [RESULT_CAP];
   logic              buf_we;

   logic              start;
   logic [5:0]        eff_decl, eff_bw;
   logic              eff_rej, eff_acc;
   logic              store_data;
   logic              ring_empty;
   logic              emit_last;
   logic [31:0]       free_wide;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Push admission, evaluated against the item at the head of the command queue.
   assign start      = !inside_ff;
   assign eff_decl   = start ? cmd.len : decl_ff;
   assign eff_bw     = start ? 6'd0 : bw_ff;
   assign eff_rej    = start ? (32'(cmd.len) > MAX_PAYLOAD) : rej_ff;
   assign eff_acc    = start ? (!eff_rej && ((32'(cmd.len) + 32'd1) <= 32'(free_ff)))
                             : acc_ff;
   assign store_data = eff_acc && (eff_bw < eff_decl);
   assign ring_empty = (free_ff == FREE_W'(RING_DEPTH));
   assign emit_last  = ((CNT_W'(idx_ff) + 1'b1) == n_ff);
   assign free_wide  = 32'(free_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.is_pop) begin
                  state_in = ring_empty ? ST_RESULT : ST_WALK_WAIT;
               end else if (cmd.last) begin
                  state_in = eff_acc ? ST_SEP : ST_RESULT;
               end
            end
         end
         ST_SEP: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_full) state_in = ST_IDLE;
         end
         ST_WALK_WAIT: state_in = ST_WALK_CHECK;
         ST_WALK_CHECK: begin
            if (ring_empty || (ring_rd_ff == separator)) begin
               state_in = (n_ff == '0) ? ST_RESULT : ST_EMIT;
            end else if (n_ff == CNT_W'(RESULT_CAP)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_WALK_WAIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_full && emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      free_in   = free_ff;
      inside_in = inside_ff;
      acc_in    = acc_ff;
      rej_in    = rej_ff;
      bw_in     = bw_ff;
      decl_in   = decl_ff;
      status_in = status_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = cmd.data;
      buf_we    = 1'b0;
      cmd_take  = 1'b0;
      rsp_push  = 1'b0;
      rsp_item.data_out   = 8'd0;
      rsp_item.byte_valid = 1'b0;
      rsp_item.last_out   = 1'b1;
      rsp_item.status     = status_ff;
      rsp_item.is_empty   = ring_empty;
      rsp_item.free_count = free_wide[8:0];

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd.is_pop) begin
                  status_in = ring_empty ? STATUS_POP_EMPTY : STATUS_OK;
                  n_in      = '0;
               end else begin
                  inside_in = 1'b1;
                  decl_in   = eff_decl;
                  rej_in    = eff_rej;
                  acc_in    = eff_acc;
                  bw_in     = eff_bw;
                  if (store_data) begin
                     mem_we  = 1'b1;
                     wp_in   = ptr_next(wp_ff);
                     free_in = (free_ff != '0) ? free_ff - 1'b1 : free_ff;
                     bw_in   = eff_bw + 6'd1;
                  end
                  if (cmd.last) begin
                     inside_in = 1'b0;
                     acc_in    = 1'b0;
                     bw_in     = 6'd0;
                     if (eff_acc)      status_in = STATUS_OK;
                     else if (eff_rej) status_in = STATUS_TOO_LONG;
                     else              status_in = STATUS_NO_SPACE;
                  end
               end
            end
         end
         ST_SEP: begin
            // Write pointer already moved past any data byte of this item.
            mem_we    = 1'b1;
            mem_wdata = separator;
            wp_in     = ptr_next(wp_ff);
            free_in   = (free_ff != '0) ? free_ff - 1'b1 : free_ff;
         end
         ST_RESULT: begin
            rsp_push = !rsp_full;
         end
         ST_WALK_WAIT: begin
         end
         ST_WALK_CHECK: begin
            idx_in = '0;
            if (!ring_empty) begin
               if (ring_rd_ff == separator) begin
                  rp_in   = ptr_next(rp_ff);
                  free_in = free_ff + 1'b1;
               end else if (n_ff != CNT_W'(RESULT_CAP)) begin
                  rp_in   = ptr_next(rp_ff);
                  free_in = free_ff + 1'b1;
                  buf_we  = 1'b1;
                  n_in    = n_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            rsp_push            = !rsp_full;
            rsp_item.data_out   = buf_ff[idx_ff];
            rsp_item.byte_valid = 1'b1;
            rsp_item.last_out   = emit_last;
            rsp_item.status     = STATUS_OK;
            if (!rsp_full) idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         rp_ff     <= '0;
         free_ff   <= FREE_W'(RING_DEPTH);
         inside_ff <= 1'b0;
         acc_ff    <= 1'b0;
         rej_ff    <= 1'b0;
         bw_ff     <= 6'd0;
         decl_ff   <= 6'd0;
         status_ff <= STATUS_OK;
         n_ff      <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         free_ff   <= free_in;
         inside_ff <= inside_in;
         acc_ff    <= acc_in;
         rej_ff    <= rej_in;
         bw_ff     <= bw_in;
         decl_ff   <= decl_in;
         status_ff <= status_in;
         n_ff      <= n_in;
         idx_ff    <= idx_in;
      end
   end

   // Ring: one write port, one registered read port that follows the read pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      ring_rd_ff <= ring_mem[rp_ff];
   end

   // Popped bytes wait here until the walk has settled the final free count.
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[n_ff[IDX_W-1:0]] <= ring_rd_ff;
      end
   end

endmodule

// ===== design/dmrq_rsp_queue.sv =====
// Result queue between the back end and the response port.
`timescale 1ns / 1ps

module dmrq_rsp_queue
   import dmrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type item_in,
   output logic    full,
   output logic    empty,
   output rsp_type item_out,
   input  logic    pop
);

   rsp_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_en, rd_en;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign item_out = slot_ff[rd_ptr_ff];
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== design/delimited_message_ring_queue.sv =====
// Top level of the delimited message ring queue.
`timescale 1ns / 1ps

// Byte ring of RING_DEPTH slots holding messages that each end in a stored
// separator byte (csr_data, reset 10). Push items carry one message byte
// each; the first item of a message brings its length, which must be at most
// MAX_PAYLOAD with length + 1 slots free, or the whole message is dropped.
// Only the last push item of a message returns a result (its status). A pop
// item returns the oldest message's bytes, at most 32, the final one marked
// last_out; all results of a pop show the free count after the whole walk.
// In the back end a last push item writes its separator (ST_SEP) before its
// result (ST_RESULT) if accepted, and goes straight to its result if rejected.
// A pop walks the ring one slot at a time (ST_WALK_WAIT, ST_WALK_CHECK), paced
// by the registered read port of the ring, then emits its bytes (ST_EMIT). A
// 2-entry command queue lets push items arrive while a pop is walking; a
// 2-entry result queue decouples rsp_pop. The ring itself needs no clearing
// pass after reset.
module delimited_message_ring_queue
   import dmrq_pkg::*;
#(
   parameter int RING_DEPTH  = 256,
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   // request items
   input  logic       req_push,
   input  req_type    req_item,
   output logic       req_full,
   // result items
   input  logic       rsp_pop,
   output rsp_type    rsp_item,
   output logic       rsp_empty,
   // separator register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_take;
   logic       back_push;
   rsp_type    back_item;
   logic       back_full;
   logic [7:0] separator_ff;

   // The register is always writable; pops compare against its current value.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= SEPARATOR_RESET;
      end else if (csr_valid && csr_ready) begin
         separator_ff <= csr_data;
      end
   end

   dmrq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   dmrq_back #(
      .RING_DEPTH  (RING_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .separator (separator_ff),
      .rsp_push  (back_push),
      .rsp_item  (back_item),
      .rsp_full  (back_full)
   );

   dmrq_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (back_push),
      .item_in  (back_item),
      .full     (back_full),
      .empty    (rsp_empty),
      .item_out (rsp_item),
      .pop      (rsp_pop)
   );

endmodule

// ===== tb/tb_delimited_message_ring_queue.sv =====
// Self-checking testbench for the delimited message ring queue.
`timescale 1ns / 1ps

module tb_delimited_message_ring_queue;
   import dmrq_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int MAX_PAYLOAD = 32;

   typedef logic [7:0] byte_list_type[$];

   // DUT ports, all inputs driven to known values from time zero
   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   req_type    req_item  = '0;
   logic       req_full;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_item;
   logic       rsp_empty;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = 8'd0;

   // Shadow copy of the ring and its bookkeeping
   logic [7:0]  ring_copy [RING_DEPTH];
   int unsigned head_idx     = 0;
   int unsigned tail_idx     = 0;
   int unsigned slots_free   = RING_DEPTH;
   bit          msg_open     = 1'b0;
   bit          msg_taken    = 1'b0;
   bit          msg_too_long = 1'b0;
   int unsigned msg_bytes    = 0;
   int unsigned msg_len      = 0;
   logic [7:0]  separator    = SEPARATOR_RESET;

   // Results still owed by the block, oldest first
   rsp_type     pending_rsps[$];
   int          error_count   = 0;
   int          items_sent    = 0;
   bit          tx_idling     = 1'b1;
   bit          rx_idling     = 1'b1;
   int          rx_hold_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   delimited_message_ring_queue #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .rsp_pop  (rsp_pop),
      .rsp_item (rsp_item),
      .rsp_empty(rsp_empty),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Flags of a result always show the ring after the whole item.
   function automatic rsp_type ring_rsp(logic [7:0] data, logic valid, logic last,
                                        logic [1:0] st);
      rsp_type r;
      r.data_out   = data;
      r.byte_valid = valid;
      r.last_out   = last;
      r.status     = st;
      r.is_empty   = (slots_free == RING_DEPTH);
      r.free_count = 9'(slots_free);
      return r;
   endfunction

   task automatic ring_store_byte(logic [7:0] b);
      ring_copy[tail_idx] = b;
      tail_idx = (tail_idx + 1) % RING_DEPTH;
      if (slots_free > 0) slots_free--;
   endtask

   // Advance the shadow ring by one accepted item, queue what it should return.
   task automatic predict_ring_results(req_type it);
      logic [1:0] st;
      logic [7:0] b;
      logic [7:0] walked[$];
      if (it.mode == MODE_PUSH) begin
         // length and admission are decided on the opening byte only
         if (!msg_open) begin
            msg_open     = 1'b1;
            msg_bytes    = 0;
            msg_len      = it.message_length;
            msg_too_long = msg_len > MAX_PAYLOAD;
            msg_taken    = !msg_too_long && (msg_len + 1 <= slots_free);
         end
         // surplus bytes past the declared length are dropped
         if (msg_taken && msg_bytes < msg_len) begin
            ring_store_byte(it.data_byte);
            msg_bytes++;
         end
         if (it.last_byte) begin
            st = STATUS_OK;
            if (msg_taken) ring_store_byte(separator);
            else st = msg_too_long ? STATUS_TOO_LONG : STATUS_NO_SPACE;
            msg_open  = 1'b0;
            msg_taken = 1'b0;
            msg_bytes = 0;
            pending_rsps.push_back(ring_rsp(8'd0, 1'b0, 1'b1, st));
         end
      end else if (slots_free >= RING_DEPTH) begin
         pending_rsps.push_back(ring_rsp(8'd0, 1'b0, 1'b1, STATUS_POP_EMPTY));
      end else begin
         // walk from head: stop on the separator (consumed), on running out of
         // stored bytes, or once a full result burst has been collected
         while (slots_free < RING_DEPTH) begin
            b = ring_copy[head_idx];
            if (b == separator) begin
               head_idx = (head_idx + 1) % RING_DEPTH;
               slots_free++;
               break;
            end
            if (walked.size() >= RESULT_CAP) break;
            head_idx = (head_idx + 1) % RING_DEPTH;
            slots_free++;
            walked.push_back(b);
         end
         if (walked.size() == 0)
            pending_rsps.push_back(ring_rsp(8'd0, 1'b0, 1'b1, STATUS_OK));
         else
            foreach (walked[k])
               pending_rsps.push_back(ring_rsp(walked[k], 1'b1,
                                               k == walked.size() - 1, STATUS_OK));
      end
   endtask

   // Offer one item; returns at the edge that took it.
   task automatic send_item(req_type it);
      int gap;
      gap = tx_idling ? idle_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      // req_full is settled by the falling edge and holds to the next rise
      @(negedge clock);
      while (req_full) @(negedge clock);
      @(posedge clock);
      items_sent++;
      predict_ring_results(it);
   endtask

   task automatic send_pop();
      req_type it;
      it.mode           = MODE_POP;
      it.data_byte      = 8'($urandom_range(0, 255));
      it.message_length = 6'($urandom_range(0, 63));
      it.last_byte      = 1'($urandom_range(0, 1));
      send_item(it);
   endtask

   // One push item per byte; only the first one's length counts.
   task automatic send_message(logic [5:0] len, byte_list_type bytes, bit closed = 1'b1);
      req_type it;
      foreach (bytes[k]) begin
         it.mode           = MODE_PUSH;
         it.data_byte      = bytes[k];
         it.message_length = (k == 0) ? len : 6'($urandom_range(0, 63));
         it.last_byte      = closed && (k == bytes.size() - 1);
         send_item(it);
      end
   endtask

   task automatic send_random_message(int unsigned len, int unsigned count,
                                      bit with_separators);
      byte_list_type bytes;
      logic [7:0]    b;
      repeat (count) begin
         b = 8'($urandom_range(0, 255));
         if (with_separators && $urandom_range(0, 15) == 0) b = separator;
         else if (!with_separators && b == separator) b = b ^ 8'h80;
         bytes.push_back(b);
      end
      send_message(6'(len), bytes);
   endtask

   // Only lowers req_push if it is still up from the last accepted item.
   task automatic wait_drained();
      if (req_push) req_push <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Separator writes only happen with the block quiet.
   task automatic write_separator(logic [7:0] value);
      wait_drained();
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      separator = value;
   endtask

   task automatic test_pop_on_empty();
      send_pop();
      send_pop();
      wait_drained();
   endtask

   task automatic test_simple_messages();
      byte_list_type msg;
      msg = {8'hFF};
      send_message(6'd0, msg);            // empty message, data ignored
      msg = {8'h00, 8'hFF, 8'h55};
      send_message(6'd3, msg);
      msg = {8'hAA};
      send_message(6'd1, msg);
      repeat (4) send_pop();              // last one finds the ring empty
      wait_drained();
   endtask

   task automatic test_length_limits();
      byte_list_type msg;
      msg = {8'h41, 8'h42};
      send_message(6'(MAX_PAYLOAD), msg); // longest legal length, sent short
      msg = {8'h01, 8'h02};
      send_message(6'(MAX_PAYLOAD + 1), msg);
      msg = {8'h12};
      send_message(6'd63, msg);
      send_pop();
      send_pop();
      wait_drained();
   endtask

   task automatic test_length_mismatch();
      byte_list_type msg;
      msg = {8'h01, 8'h02, 8'h03, 8'h04};
      send_message(6'd2, msg);            // two bytes too many
      msg = {8'h07, 8'h08};
      send_message(6'd5, msg);            // three bytes short
      repeat (3) send_pop();
      wait_drained();
   endtask

   task automatic test_separator_in_payload();
      byte_list_type msg;
      msg = {8'h01, separator, 8'h03, 8'h04};
      send_message(6'd4, msg);
      repeat (3) send_pop();
      wait_drained();
   endtask

   task automatic test_pop_mid_message();
      byte_list_type msg;
      msg = {8'h21, 8'h22};
      send_message(6'd5, msg, 1'b0);      // message left open
      send_pop();
      msg = {8'h23, 8'h24, 8'h25};
      send_message(6'd5, msg);
      send_pop();
      send_pop();
      wait_drained();
   endtask

   // A zero separator splits a payload that holds a zero byte.
   task automatic test_separator_change();
      byte_list_type msg;
      write_separator(8'h00);
      msg = {8'h05, 8'h00, 8'h06};
      send_message(6'd3, msg);
      repeat (3) send_pop();
      write_separator(SEPARATOR_RESET);
   endtask

   task automatic test_ring_full();
      byte_list_type msg;
      tx_idling = 1'b0;
      wait_drained();
      // one-byte messages take two slots each: all but two slots used
      repeat ((RING_DEPTH / 2) - 1) begin
         msg = {8'($urandom_range(16, 200))};
         send_message(6'd1, msg);
      end
      msg = {8'h31};
      send_message(6'd2, msg);            // needs three slots, no room
      msg = {8'h32};
      send_message(6'd1, msg);            // exact fit, ring now full
      msg = {8'h33};
      send_message(6'd0, msg);            // even an empty message needs a slot
      // old separators are now plain data: every pop hits its burst cap,
      // the last one finds the ring empty
      write_separator(8'hFF);
      repeat ((RING_DEPTH / RESULT_CAP) + 1) send_pop();
      write_separator(SEPARATOR_RESET);
      tx_idling = 1'b1;
   endtask

   // Receiver stops while the sender keeps going, so both queues fill and
   // req_full has to hold the sender off.
   task automatic test_backpressure();
      byte_list_type msg;
      wait_drained();
      rx_hold_cycles = 300;
      repeat (6) begin
         send_pop();
         msg = {8'($urandom_range(0, 255))};
         send_message(6'd0, msg);
      end
      send_pop();
      wait_drained();
   endtask

   task automatic test_random_traffic(int n_items);
      int          start;
      int          r;
      int unsigned len;
      int unsigned count;
      req_type     it;
      byte_list_type msg;
      start = items_sent;
      while (items_sent - start < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            r = $urandom_range(0, 99);
            if (r < 8) len = $urandom_range(MAX_PAYLOAD + 1, 63);
            else if (r < 16) len = 0;
            else len = $urandom_range(1, MAX_PAYLOAD);
            r = $urandom_range(0, 99);
            if (len > MAX_PAYLOAD) count = $urandom_range(1, 6);
            else if (len == 0) count = $urandom_range(1, 2);
            else if (r < 80) count = len;
            else if (r < 90) count = $urandom_range(1, len);
            else count = len + $urandom_range(1, 3);
            send_random_message(len, count, 1'b1);
         end else if (r < 90) begin
            send_pop();
         end else begin
            // stray item with every field random
            it = req_type'(16'($urandom));
            send_item(it);
         end
      end
      // leave no message open across a separator write
      if (msg_open) begin
         msg = {8'($urandom_range(0, 255))};
         send_message(6'($urandom_range(0, 63)), msg);
      end
      wait_drained();
   endtask

   // Receiver: pops at random and checks every result it takes.
   initial begin : result_checker
      rsp_type want;
      int      gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rsp_pop <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (rx_idling) gap_left = idle_gap();
            rsp_pop <= (gap_left == 0);
         end
         // handshake is decided by values that hold until the next rise
         @(negedge clock);
         if (rsp_pop && !rsp_empty && !reset) begin
            if (pending_rsps.size() == 0) begin
               $error("unexpected result: data_out %0d status %0d",
                      rsp_item.data_out, rsp_item.status);
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_item.data_out !== want.data_out) begin
                  $error("data_out: expected %0d, actual %0d",
                         want.data_out, rsp_item.data_out);
                  error_count++;
               end
               if (rsp_item.byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %0d, actual %0d",
                         want.byte_valid, rsp_item.byte_valid);
                  error_count++;
               end
               if (rsp_item.last_out !== want.last_out) begin
                  $error("last_out: expected %0d, actual %0d",
                         want.last_out, rsp_item.last_out);
                  error_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d",
                         want.status, rsp_item.status);
                  error_count++;
               end
               if (rsp_item.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d",
                         want.is_empty, rsp_item.is_empty);
                  error_count++;
               end
               if (rsp_item.free_count !== want.free_count) begin
                  $error("free_count: expected %0d, actual %0d",
                         want.free_count, rsp_item.free_count);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pop_on_empty();
      test_simple_messages();
      test_length_limits();
      test_length_mismatch();
      test_separator_in_payload();
      test_pop_mid_message();
      test_separator_change();
      test_ring_full();
      test_backpressure();

      write_separator(8'($urandom_range(0, 255)));
      test_random_traffic(10);
      // a stretch with no idling on either side
      tx_idling = 1'b0;
      rx_idling = 1'b0;
      test_random_traffic(10);
      tx_idling = 1'b1;
      rx_idling = 1'b1;
      write_separator(SEPARATOR_RESET);
      test_random_traffic(10);

      wait_drained();
      repeat (150) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/dmrq_pkg.sv
design/dmrq_front.sv
design/dmrq_back.sv
design/dmrq_rsp_queue.sv
design/delimited_message_ring_queue.sv
tb/tb_delimited_message_ring_queue.sv
